// ===== src/lqfl_pkg.sv =====
package lqfl_pkg;

   // Default number of cells in the store.
   localparam int DEPTH_DEFAULT = 16;

   // Byte returned by a peek at an empty queue.
   localparam logic [7:0] DASH_CHAR = 8'd45;

   typedef enum logic [1:0] {
      OP_ENQ  = 2'd0,
      OP_DEQ  = 2'd1,
      OP_PEEK = 2'd2,
      OP_CLR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_INIT,
      S_IDLE,
      S_FIN
   } state_type;

   // Strobes for the two cell memories.
   typedef struct packed {
      logic next_we;
      logic next_re;
      logic value_we;
      logic value_re;
   } mem_ctl_type;

endpackage

// ===== src/linked_queue_with_free_list_top.sv =====
// A request word is accepted in the idle state; the completion state then registers
// its result word, and a new request word is taken only once that is done. A request
// may read a link or byte from the cell store's registered read port and write back.
// A stalled result word holds the next request in its completion cycle.
// Reset is synchronous and active high; after it the cell store initialises the link
// of each cell in turn, and req_stall stays high until the controller sees it done.
module linked_queue_with_free_list_top #(
   parameter int DEPTH = lqfl_pkg::DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [7:0] req_data_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_value_out,
   output logic       rsp_is_empty
);

   // A pointer names a cell, or holds DEPTH to mean null.
   localparam int IDX_W = $clog2(DEPTH);
   localparam int PTR_W = $clog2(DEPTH + 1);

   // Memory strobes and addresses from the controller to the cell store.
   lqfl_pkg::mem_ctl_type ctl;
   logic [IDX_W-1:0]      raddr;
   logic [IDX_W-1:0]      next_waddr;
   logic [PTR_W-1:0]      next_wdata;
   logic [IDX_W-1:0]      value_waddr;
   logic [7:0]            value_wdata;
   logic [PTR_W-1:0]      next_rdata;
   logic [7:0]            value_rdata;
   logic                  store_busy;

   // The controller keeps the head, tail and free-list pointers in registers and
   // sequences each request as an accept in the idle state followed by the completion state.
   // A clear splices the whole queue onto the free list with a single link write,
   // so it costs no more than any other request.
   lqfl_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_data_in   (req_data_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .rsp_is_empty  (rsp_is_empty),
      .ctl           (ctl),
      .raddr         (raddr),
      .next_waddr    (next_waddr),
      .next_wdata    (next_wdata),
      .value_waddr   (value_waddr),
      .value_wdata   (value_wdata),
      .next_rdata    (next_rdata),
      .value_rdata   (value_rdata),
      .store_busy    (store_busy)
   );

   // The cell store holds the link and byte memories, each with one write and one
   // registered read port, and runs the link initialisation pass after reset.
   lqfl_cell_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .raddr       (raddr),
      .next_waddr  (next_waddr),
      .next_wdata  (next_wdata),
      .value_waddr (value_waddr),
      .value_wdata (value_wdata),
      .next_rdata  (next_rdata),
      .value_rdata (value_rdata),
      .busy        (store_busy)
   );

endmodule

// ===== src/lqfl_cell_store.sv =====
module lqfl_cell_store #(
   parameter int DEPTH = lqfl_pkg::DEPTH_DEFAULT,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int PTR_W = $clog2(DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lqfl_pkg::mem_ctl_type ctl,
   input  logic [IDX_W-1:0]     raddr,
   input  logic [IDX_W-1:0]     next_waddr,
   input  logic [PTR_W-1:0]     next_wdata,
   input  logic [IDX_W-1:0]     value_waddr,
   input  logic [7:0]           value_wdata,
   output logic [PTR_W-1:0]     next_rdata,
   output logic [7:0]           value_rdata,
   output logic                 busy
);

   localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(DEPTH);

   logic [PTR_W-1:0] next_mem [DEPTH];
   logic [7:0]       value_mem [DEPTH];

   logic [IDX_W-1:0] init_cnt_ff;
   logic             busy_ff;
   logic [PTR_W-1:0] next_rd_ff;
   logic [7:0]       value_rd_ff;

   // After reset every cell is linked to the one below it, cell zero to null.
   always_ff @(posedge clock) begin
      if (reset) begin
         init_cnt_ff <= '0;
         busy_ff     <= 1'b1;
      end else if (busy_ff) begin
         init_cnt_ff <= init_cnt_ff + 1'b1;
         if (init_cnt_ff == IDX_W'(DEPTH - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         next_mem[init_cnt_ff] <= (init_cnt_ff == '0) ? NIL_PTR
                                  : PTR_W'(init_cnt_ff) - 1'b1;
      end else if (ctl.next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      if (ctl.next_re) begin
         next_rd_ff <= next_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.value_we) begin
         value_mem[value_waddr] <= value_wdata;
      end
      if (ctl.value_re) begin
         value_rd_ff <= value_mem[raddr];
      end
   end

   assign next_rdata  = next_rd_ff;
   assign value_rdata = value_rd_ff;
   assign busy        = busy_ff;

   a_no_access_in_init: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !(ctl.next_we || ctl.next_re || ctl.value_we || ctl.value_re))
      else $error("cell store accessed during the link initialisation pass");

   a_init_covers_all: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> $past(init_cnt_ff) == IDX_W'(DEPTH - 1))
      else $error("link initialisation pass ended early");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (ctl.next_we |-> int'(next_waddr) < DEPTH) and
      (ctl.value_we |-> int'(value_waddr) < DEPTH))
      else $error("cell store written outside the store");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      (ctl.next_re || ctl.value_re) |-> int'(raddr) < DEPTH)
      else $error("cell store read outside the store");

endmodule

// ===== src/lqfl_ctrl.sv =====
module lqfl_ctrl #(
   parameter int DEPTH = lqfl_pkg::DEPTH_DEFAULT,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int PTR_W = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_type,
   input  logic [7:0]            req_data_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic [7:0]            rsp_value_out,
   output logic                  rsp_is_empty,
   output lqfl_pkg::mem_ctl_type ctl,
   output logic [IDX_W-1:0]      raddr,
   output logic [IDX_W-1:0]      next_waddr,
   output logic [PTR_W-1:0]      next_wdata,
   output logic [IDX_W-1:0]      value_waddr,
   output logic [7:0]            value_wdata,
   input  logic [PTR_W-1:0]      next_rdata,
   input  logic [7:0]            value_rdata,
   input  logic                  store_busy
);

   localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(DEPTH);

   lqfl_pkg::state_type  state_ff, state_in;
   lqfl_pkg::op_type     op_ff, op_in;
   lqfl_pkg::status_type status_ff, status_in;
   logic                 ok_ff, ok_in;
   logic [7:0]           value_ff, value_in;
   logic [PTR_W-1:0]     head_ff, head_in;
   logic [PTR_W-1:0]     tail_ff, tail_in;
   logic [PTR_W-1:0]     free_ff, free_in;
   logic [PTR_W-1:0]     cur_ff, cur_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [7:0]           rsp_value_ff, rsp_value_in;
   logic                 rsp_empty_ff, rsp_empty_in;

   logic                 q_empty;
   logic                 accept;
   logic                 finish;
   lqfl_pkg::op_type     req_op;

   assign q_empty = !(head_ff < NIL_PTR);
   assign req_op  = lqfl_pkg::op_type'(req_type);
   assign accept  = req_valid && (state_ff == lqfl_pkg::S_IDLE);
   assign finish  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lqfl_pkg::S_INIT;
         head_ff      <= NIL_PTR;
         tail_ff      <= NIL_PTR;
         free_ff      <= PTR_W'(DEPTH - 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      status_ff     <= status_in;
      ok_ff         <= ok_in;
      value_ff      <= value_in;
      cur_ff        <= cur_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      status_in     = status_ff;
      ok_in         = ok_ff;
      value_in      = value_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_in       = free_ff;
      cur_in        = cur_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_empty_in  = rsp_empty_ff;
      ctl           = '0;
      raddr         = head_ff[IDX_W-1:0];
      next_waddr    = tail_ff[IDX_W-1:0];
      next_wdata    = free_ff;
      value_waddr   = free_ff[IDX_W-1:0];
      value_wdata   = req_data_in;
      req_stall     = 1'b1;

      unique case (state_ff)
         lqfl_pkg::S_INIT: begin
            if (!store_busy) begin
               state_in = lqfl_pkg::S_IDLE;
            end
         end
         lqfl_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (accept) begin
               state_in  = lqfl_pkg::S_FIN;
               op_in     = req_op;
               status_in = lqfl_pkg::ST_DONE;
               ok_in     = 1'b0;
               value_in  = 8'd0;
               unique case (req_op)
                  lqfl_pkg::OP_ENQ: begin
                     if (!(free_ff < NIL_PTR)) begin
                        status_in = lqfl_pkg::ST_FULL;
                     end else begin
                        ok_in        = 1'b1;
                        cur_in       = free_ff;
                        raddr        = free_ff[IDX_W-1:0];
                        ctl.next_re  = 1'b1;
                        ctl.value_we = 1'b1;
                        ctl.next_we  = !q_empty;
                        tail_in      = free_ff;
                        if (q_empty) begin
                           head_in = free_ff;
                        end
                     end
                  end
                  lqfl_pkg::OP_DEQ: begin
                     if (q_empty) begin
                        status_in = lqfl_pkg::ST_EMPTY;
                     end else begin
                        ok_in       = 1'b1;
                        cur_in      = head_ff;
                        ctl.next_re = 1'b1;
                     end
                  end
                  lqfl_pkg::OP_PEEK: begin
                     if (q_empty) begin
                        status_in = lqfl_pkg::ST_EMPTY;
                        value_in  = lqfl_pkg::DASH_CHAR;
                     end else begin
                        ok_in        = 1'b1;
                        ctl.value_re = 1'b1;
                     end
                  end
                  lqfl_pkg::OP_CLR: begin
                     if (q_empty) begin
                        status_in = lqfl_pkg::ST_EMPTY;
                     end else begin
                        // The whole chain is spliced onto the front of the free list.
                        ctl.next_we = 1'b1;
                        free_in     = head_ff;
                        head_in     = NIL_PTR;
                        tail_in     = NIL_PTR;
                     end
                  end
               endcase
            end
         end
         lqfl_pkg::S_FIN: begin
            if (finish) begin
               state_in   = lqfl_pkg::S_IDLE;
               next_waddr = cur_ff[IDX_W-1:0];
               if (ok_ff && op_ff == lqfl_pkg::OP_ENQ) begin
                  free_in     = (next_rdata < NIL_PTR) ? next_rdata : NIL_PTR;
                  next_wdata  = NIL_PTR;
                  ctl.next_we = 1'b1;
               end
               if (ok_ff && op_ff == lqfl_pkg::OP_DEQ) begin
                  head_in     = (next_rdata < NIL_PTR) ? next_rdata : NIL_PTR;
                  if (!(next_rdata < NIL_PTR)) begin
                     tail_in = NIL_PTR;
                  end
                  next_wdata  = free_ff;
                  free_in     = cur_ff;
                  ctl.next_we = 1'b1;
               end
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = (ok_ff && op_ff == lqfl_pkg::OP_PEEK) ? value_rdata : value_ff;
               rsp_empty_in  = !(head_in < NIL_PTR);
            end
         end
         default: begin
            state_in = lqfl_pkg::S_INIT;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_is_empty  = rsp_empty_ff;

   a_accept_to_fin: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == lqfl_pkg::S_FIN)
      else $error("accepted word did not move on to completion");

   a_head_tail_agree: assert property (@(posedge clock) disable iff (reset)
      state_ff == lqfl_pkg::S_IDLE |-> ((head_ff < NIL_PTR) == (tail_ff < NIL_PTR)))
      else $error("head and tail pointers disagree on emptiness");

   a_cells_not_lost: assert property (@(posedge clock) disable iff (reset)
      state_ff == lqfl_pkg::S_IDLE |-> !(head_ff == NIL_PTR && free_ff == NIL_PTR))
      else $error("queue and free list both empty");

   a_result_follows_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lqfl_pkg::S_FIN && finish) |=> rsp_valid_ff)
      else $error("completed request produced no result word");

endmodule

// ===== bench/lqfl_checker.sv =====
`timescale 1ns / 100ps

module lqfl_checker #(
   parameter int DEPTH = lqfl_pkg::DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [7:0] req_data_in,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [1:0] rsp_status,
   input  logic [7:0] rsp_value_out,
   input  logic       rsp_is_empty,
   output int         fail_count,
   output int         pending_count
);
   import lqfl_pkg::*;

   localparam int PW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] NIL = PW'(DEPTH);

   typedef struct packed {
      status_type status;
      logic [7:0] value;
      logic       empty;
   } queue_answer;

   logic [7:0]    byte_store [DEPTH];
   logic [PW-1:0] link_store [DEPTH];
   logic [PW-1:0] head_cell;
   logic [PW-1:0] tail_cell;
   logic [PW-1:0] free_cell;
   queue_answer   answers_due [$];
   queue_answer   want;
   queue_answer   got;
   int            mismatches = 0;

   function automatic logic names_cell(logic [PW-1:0] p);
      return int'(p) < DEPTH;
   endfunction

   task automatic reset_store();
      for (int i = 0; i < DEPTH; i++) begin
         byte_store[i] = 8'd0;
         link_store[i] = (i == 0) ? NIL : PW'(i - 1);
      end
      head_cell = NIL;
      tail_cell = NIL;
      free_cell = PW'(DEPTH - 1);
   endtask

   // Unlinks the head cell and pushes it onto the free list.
   task automatic release_head_cell();
      logic [PW-1:0] c;
      logic [PW-1:0] nx;
      c = head_cell;
      if (names_cell(c)) begin
         nx = link_store[c];
         head_cell = names_cell(nx) ? nx : NIL;
         if (!names_cell(head_cell))
            tail_cell = NIL;
         link_store[c] = free_cell;
         free_cell = c;
      end
   endtask

   task automatic predict_queue_op(input op_type op, input logic [7:0] byte_in,
                                   output queue_answer ans);
      logic [PW-1:0] c;
      logic [PW-1:0] nx;
      ans.status = ST_DONE;
      ans.value = 8'd0;
      case (op)
         OP_ENQ: begin
            c = free_cell;
            if (!names_cell(c)) begin
               ans.status = ST_FULL;
            end else begin
               nx = link_store[c];
               free_cell = names_cell(nx) ? nx : NIL;
               byte_store[c] = byte_in;
               link_store[c] = NIL;
               if (!names_cell(head_cell) || !names_cell(tail_cell))
                  head_cell = c;
               else
                  link_store[tail_cell] = c;
               tail_cell = c;
            end
         end
         OP_DEQ: begin
            if (!names_cell(head_cell))
               ans.status = ST_EMPTY;
            else
               release_head_cell();
         end
         OP_PEEK: begin
            if (!names_cell(head_cell)) begin
               ans.status = ST_EMPTY;
               ans.value = DASH_CHAR;
            end else begin
               ans.value = byte_store[head_cell];
            end
         end
         default: begin
            if (!names_cell(head_cell)) begin
               ans.status = ST_EMPTY;
            end else begin
               for (int n = 0; n < DEPTH && names_cell(head_cell); n++)
                  release_head_cell();
               head_cell = NIL;
               tail_cell = NIL;
            end
         end
      endcase
      ans.empty = !names_cell(head_cell);
   endtask

   // A result word always belongs to an earlier request, so it is checked
   // before the request accepted at the same edge is predicted.
   always @(posedge clock) begin
      if (reset) begin
         reset_store();
         answers_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.status = status_type'(rsp_status);
            got.value = rsp_value_out;
            got.empty = rsp_is_empty;
            if (answers_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result word with none due: status %0d value %02h empty %0b",
                           $realtime, rsp_status, rsp_value_out, rsp_is_empty);
            end else begin
               want = answers_due.pop_front();
               if (got.status !== want.status || got.value !== want.value ||
                   got.empty !== want.empty) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: status exp %0d got %0d, value exp %02h got %02h, %s",
                              $realtime, want.status, rsp_status, want.value,
                              rsp_value_out,
                              $sformatf("empty exp %0b got %0b", want.empty, rsp_is_empty));
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_queue_op(op_type'(req_type), req_data_in, want);
            answers_due.push_back(want);
         end
      end
      fail_count <= mismatches;
      pending_count <= answers_due.size();
   end

endmodule

// ===== bench/linked_queue_with_free_list_top_tb.sv =====
`timescale 1ns / 100ps

module linked_queue_with_free_list_top_tb;
   import lqfl_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   // Far above the slowest correct run: about 1600 words, with random gaps on the
   // sender side and random result stalls.
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_WORDS = 1550;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_type = OP_PEEK;
   logic [7:0] req_data_in = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [7:0] rsp_value_out;
   logic       rsp_is_empty;

   // While calm is set neither side idles, which gives the block a long
   // stretch at its full rate.
   logic calm = 1'b0;
   int   fail_count;
   int   pending_count;
   int   cycle_count = 0;

   linked_queue_with_free_list_top #(
      .DEPTH(DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_data_in(req_data_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_value_out(rsp_value_out),
      .rsp_is_empty(rsp_is_empty)
   );

   lqfl_checker #(
      .DEPTH(DEPTH)
   ) queue_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_data_in(req_data_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_value_out(rsp_value_out),
      .rsp_is_empty(rsp_is_empty),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   always #5 clock = ~clock;

   // The result side stalls at random about a fifth of the time, never while
   // calm is set.
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 22);
   end

   // Presents one request word and holds it until the block takes it. The
   // stall seen straight after the edge is the one that decided that edge.
   // Afterwards the sender may idle at random; when it does not, the next word
   // follows at once without valid being dropped.
   task automatic send_word(input op_type op, input logic [7:0] byte_in);
      req_valid <= 1'b1;
      req_type <= op;
      req_data_in <= byte_in;
      do @(posedge clock); while (req_stall);
      if (!calm && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         req_type <= 2'($urandom_range(3));
         req_data_in <= 8'($urandom_range(255));
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Waits until every predicted result word has come back. The count is
   // registered, so the loop passes a clock edge before it first reads it.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Two mixes of requests: one that tends to fill the store and one that
   // tends to empty it, so that the level sweeps between empty and full.
   // Clears are kept rare, otherwise the full case would hardly be reached.
   function automatic op_type pick_op(input logic filling);
      int r;
      r = $urandom_range(99);
      if (filling) begin
         if (r < 58) return OP_ENQ;
         if (r < 83) return OP_DEQ;
         if (r < 98) return OP_PEEK;
         return OP_CLR;
      end
      if (r < 30) return OP_ENQ;
      if (r < 78) return OP_DEQ;
      if (r < 98) return OP_PEEK;
      return OP_CLR;
   endfunction

   // The run is stopped here if the block hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      logic [7:0] pattern;
      logic       filling;
      filling = 1'b0;

      // Reset is held and then released; the block then initialises its links
      // and stalls the first word until that is done.
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Peek, dequeue and clear on an empty queue.
      send_word(OP_PEEK, 8'h5A);
      send_word(OP_DEQ, 8'hA5);
      send_word(OP_CLR, 8'hFF);

      // A single word in and out again.
      send_word(OP_ENQ, 8'h00);
      send_word(OP_PEEK, 8'hFF);
      send_word(OP_DEQ, 8'h00);

      // Fill every cell with walking ones and then walking zeros, so that each
      // data bit is seen at both values, then try one more while full.
      for (int k = 0; k < DEPTH; k++) begin
         pattern = 8'h01 << (k % 8);
         if (k >= 8)
            pattern = ~pattern;
         send_word(OP_ENQ, pattern);
      end
      send_word(OP_ENQ, 8'hFF);
      send_word(OP_PEEK, 8'h00);

      // Clear a full queue, which splices the whole list onto the free list.
      send_word(OP_CLR, 8'h00);

      // Random part: the mix alternates every sixty words. A long stretch in
      // the middle runs with no idling on either side, and once the sender
      // holds off until every result word has come back.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 60 == 0)
            filling = !filling;
         calm <= (n >= 400 && n < 650);
         if (n == 900)
            wait_drained();
         send_word(pick_op(filling), 8'($urandom_range(255)));
      end

      // All requests are in; let the last results arrive, then keep running so
      // that any stray word can still show up.
      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
